// ===== sv/scc_pkg.sv =====
// package: constants, codes and transaction types of the snooping cache controller
`default_nettype none
package scc_pkg;
  localparam int SET_IDX_W = 6;
  localparam int WAYS     = 4;
  localparam int OFF_W    = 6;
  localparam int NUM_SETS = 1 << SET_IDX_W;
  localparam int TAG_W    = 32 - SET_IDX_W;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RANK_W   = WAY_W;
  localparam int SET_AW   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int QDEPTH   = 2;

  localparam logic [1:0] OP_PRD   = 2'd0;
  localparam logic [1:0] OP_PWR   = 2'd1;
  localparam logic [1:0] OP_BUSRD = 2'd2;
  localparam logic [1:0] OP_BUSRDX = 2'd3;

  localparam logic [1:0] ST_I = 2'd0;
  localparam logic [1:0] ST_S = 2'd1;
  localparam logic [1:0] ST_E = 2'd2;
  localparam logic [1:0] ST_M = 2'd3;

  localparam logic [1:0] CMD_NONE   = 2'd0;
  localparam logic [1:0] CMD_BUSRD  = 2'd1;
  localparam logic [1:0] CMD_BUSRDX = 2'd2;
  localparam logic [1:0] CMD_FLUSH  = 2'd3;

  localparam logic REG_MODE = 1'b0;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] address;
    logic        others_have_copy;
  } in_t;

  typedef struct packed {
    logic        last;
    logic [1:0]  bus_command;
    logic [31:0] bus_block_address;
    logic        assert_shared;
    logic        hit;
    logic [31:0] read_count;
    logic [31:0] write_count;
    logic [31:0] read_miss_count;
    logic [31:0] write_miss_count;
    logic [31:0] invalidation_count;
    logic [31:0] writeback_count;
  } out_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] blk;
    logic        others;
  } req_t;
endpackage
`default_nettype wire

// ===== sv/scc_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none
module scc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== sv/scc_front.sv =====
// front end: accepts transactions, forms the block address, queues requests
`default_nettype none
module scc_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire scc_pkg::in_t  in_data,
  output logic               q_valid,
  output scc_pkg::req_t      q_data,
  input  wire logic          q_pop
);
  scc_pkg::req_t buf_r [scc_pkg::QDEPTH];
  logic [0:0] wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  scc_pkg::req_t req;

  always_comb begin
    req.op     = in_data.opcode;
    req.others = in_data.others_have_copy;
    if (in_data.opcode == scc_pkg::OP_PRD || in_data.opcode == scc_pkg::OP_PWR) begin
      req.blk = in_data.address >> scc_pkg::OFF_W;
    end else begin
      req.blk = in_data.address;
    end
  end

  assign in_stall = (cnt_r == 2'(scc_pkg::QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= req;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (q_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

// ===== sv/scc_back.sv =====
// back end: set lookup, coherence update, lru, counters and result slots
`default_nettype none
module scc_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          mode,
  input  wire logic          q_valid,
  input  wire scc_pkg::req_t q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output scc_pkg::out_t      out_data
);
  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;
  localparam int SROW_W = scc_pkg::WAYS * (2 + scc_pkg::RANK_W);
  localparam int TROW_W = scc_pkg::WAYS * scc_pkg::TAG_W;

  logic                  fsm_r;
  scc_pkg::req_t         req_r;
  logic                  rvld_r;
  logic [scc_pkg::NUM_SETS-1:0] set_vld_r;
  logic [31:0]           cnt_r [6];
  logic [31:0]           cnt_nxt [6];
  scc_pkg::out_t         slot_r [2];
  logic [1:0]            nres_r;

  logic [SROW_W-1:0] srow_rd, srow_wr;
  logic [TROW_W-1:0] trow_rd, trow_wr;
  logic              twe;

  logic [scc_pkg::SET_AW-1:0] rset, eset;
  logic [scc_pkg::TAG_W-1:0]  etag;
  logic [1:0]                 st [scc_pkg::WAYS];
  logic [scc_pkg::RANK_W-1:0] rk [scc_pkg::WAYS];
  logic [scc_pkg::TAG_W-1:0]  tg [scc_pkg::WAYS];
  logic [1:0]                 st_n [scc_pkg::WAYS];
  logic [scc_pkg::RANK_W-1:0] rk_n [scc_pkg::WAYS];
  logic                       hit, found_inv, is_proc, do_touch, flush2;
  logic [scc_pkg::WAY_W-1:0]  hway, inv_way, lru_way, vic, tway;
  logic [1:0]                 cmd0;
  logic [31:0]                badr0, badr1;
  logic                       exec_go, out_acc;
  scc_pkg::out_t              r0, r1;

  assign rset    = q_data.blk[scc_pkg::SET_AW-1:0];
  assign eset    = req_r.blk[scc_pkg::SET_AW-1:0];
  assign etag    = req_r.blk[31:scc_pkg::SET_IDX_W];
  assign is_proc = (req_r.op == scc_pkg::OP_PRD) || (req_r.op == scc_pkg::OP_PWR);
  assign q_pop   = (fsm_r == S_IDLE) && q_valid;
  assign out_acc = out_valid && !out_stall;
  assign exec_go = (fsm_r == S_EXEC) && ((nres_r == 2'd0) || (nres_r == 2'd1 && out_acc));

  scc_ram #(.WIDTH(SROW_W), .DEPTH(scc_pkg::NUM_SETS)) u_sram (
    .clk(clk), .we(exec_go), .waddr(eset), .wdata(srow_wr),
    .re(q_pop), .raddr(rset), .rdata(srow_rd)
  );

  scc_ram #(.WIDTH(TROW_W), .DEPTH(scc_pkg::NUM_SETS)) u_tram (
    .clk(clk), .we(exec_go && twe), .waddr(eset), .wdata(trow_wr),
    .re(q_pop), .raddr(rset), .rdata(trow_rd)
  );

  always_comb begin
    for (int w = 0; w < scc_pkg::WAYS; w++) begin
      tg[w] = trow_rd[w*scc_pkg::TAG_W +: scc_pkg::TAG_W];
      if (rvld_r) begin
        st[w] = srow_rd[w*(2+scc_pkg::RANK_W) +: 2];
        rk[w] = srow_rd[w*(2+scc_pkg::RANK_W)+2 +: scc_pkg::RANK_W];
      end else begin
        st[w] = scc_pkg::ST_I;
        rk[w] = scc_pkg::RANK_W'(w);
      end
    end
    hit = 1'b0;
    hway = '0;
    found_inv = 1'b0;
    inv_way = '0;
    lru_way = '0;
    for (int w = scc_pkg::WAYS - 1; w >= 0; w--) begin
      if (st[w] != scc_pkg::ST_I && tg[w] == etag) begin
        hit = 1'b1;
        hway = scc_pkg::WAY_W'(w);
      end
      if (st[w] == scc_pkg::ST_I) begin
        found_inv = 1'b1;
        inv_way = scc_pkg::WAY_W'(w);
      end
      if (rk[w] == scc_pkg::RANK_W'(scc_pkg::WAYS - 1)) begin
        lru_way = scc_pkg::WAY_W'(w);
      end
    end
    vic = found_inv ? inv_way : lru_way;

    for (int w = 0; w < scc_pkg::WAYS; w++) begin
      st_n[w] = st[w];
      trow_wr[w*scc_pkg::TAG_W +: scc_pkg::TAG_W] = tg[w];
    end
    for (int j = 0; j < 6; j++) begin
      cnt_nxt[j] = cnt_r[j];
    end
    cmd0 = scc_pkg::CMD_NONE;
    badr0 = '0;
    badr1 = '0;
    flush2 = 1'b0;
    twe = 1'b0;
    do_touch = 1'b0;
    tway = hway;
    if (is_proc) begin
      do_touch = 1'b1;
      if (req_r.op == scc_pkg::OP_PRD) begin
        cnt_nxt[0] = cnt_r[0] + 32'd1;
      end else begin
        cnt_nxt[1] = cnt_r[1] + 32'd1;
      end
      if (hit) begin
        if (req_r.op == scc_pkg::OP_PWR) begin
          if (st[hway] == scc_pkg::ST_S) begin
            cmd0 = scc_pkg::CMD_BUSRDX;
            badr0 = req_r.blk;
          end
          st_n[hway] = scc_pkg::ST_M;
        end
      end else begin
        tway = vic;
        twe = 1'b1;
        badr0 = req_r.blk;
        if (req_r.op == scc_pkg::OP_PRD) begin
          cnt_nxt[2] = cnt_r[2] + 32'd1;
          cmd0 = scc_pkg::CMD_BUSRD;
          st_n[vic] = (mode && !req_r.others) ? scc_pkg::ST_E : scc_pkg::ST_S;
        end else begin
          cnt_nxt[3] = cnt_r[3] + 32'd1;
          cmd0 = scc_pkg::CMD_BUSRDX;
          st_n[vic] = scc_pkg::ST_M;
        end
        if (st[vic] == scc_pkg::ST_M) begin
          flush2 = 1'b1;
          badr1 = {tg[vic], eset};
          cnt_nxt[5] = cnt_r[5] + 32'd1;
        end
        trow_wr[vic*scc_pkg::TAG_W +: scc_pkg::TAG_W] = etag;
      end
    end else if (hit) begin
      if (st[hway] == scc_pkg::ST_M) begin
        cmd0 = scc_pkg::CMD_FLUSH;
        badr0 = req_r.blk;
        cnt_nxt[5] = cnt_r[5] + 32'd1;
      end
      if (req_r.op == scc_pkg::OP_BUSRD) begin
        st_n[hway] = scc_pkg::ST_S;
      end else begin
        st_n[hway] = scc_pkg::ST_I;
        cnt_nxt[4] = cnt_r[4] + 32'd1;
      end
    end

    for (int w = 0; w < scc_pkg::WAYS; w++) begin
      rk_n[w] = rk[w];
      if (do_touch) begin
        if (scc_pkg::WAY_W'(w) == tway) begin
          rk_n[w] = '0;
        end else if (rk[w] < rk[tway]) begin
          rk_n[w] = rk[w] + 1'b1;
        end
      end
      srow_wr[w*(2+scc_pkg::RANK_W) +: 2] = st_n[w];
      srow_wr[w*(2+scc_pkg::RANK_W)+2 +: scc_pkg::RANK_W] = rk_n[w];
    end

    r0.last = !flush2;
    r0.bus_command = cmd0;
    r0.bus_block_address = badr0;
    r0.assert_shared = (req_r.op == scc_pkg::OP_BUSRD) && hit;
    r0.hit = hit;
    r0.read_count = cnt_nxt[0];
    r0.write_count = cnt_nxt[1];
    r0.read_miss_count = cnt_nxt[2];
    r0.write_miss_count = cnt_nxt[3];
    r0.invalidation_count = cnt_nxt[4];
    r0.writeback_count = cnt_nxt[5];
    r1 = r0;
    r1.last = 1'b1;
    r1.bus_command = scc_pkg::CMD_FLUSH;
    r1.bus_block_address = badr1;
  end

  assign out_valid = (nres_r != 2'd0);
  assign out_data  = slot_r[0];

  always_ff @(posedge clk) begin
    if (q_pop) begin
      req_r  <= q_data;
      rvld_r <= set_vld_r[rset];
    end
    if (exec_go) begin
      slot_r[0] <= r0;
      slot_r[1] <= r1;
    end else if (out_acc) begin
      slot_r[0] <= slot_r[1];
    end
    if (!rst_n) begin
      fsm_r     <= S_IDLE;
      set_vld_r <= '0;
      nres_r    <= 2'd0;
      for (int j = 0; j < 6; j++) begin
        cnt_r[j] <= '0;
      end
    end else begin
      unique case (fsm_r)
        S_IDLE: begin
          if (q_pop) begin
            fsm_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            fsm_r <= S_IDLE;
          end
        end
        default: fsm_r <= S_IDLE;
      endcase
      if (exec_go) begin
        set_vld_r[eset] <= 1'b1;
        nres_r <= flush2 ? 2'd2 : 2'd1;
        for (int j = 0; j < 6; j++) begin
          cnt_r[j] <= cnt_nxt[j];
        end
      end else if (out_acc) begin
        nres_r <= nres_r - 2'd1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/snooping_coherent_cache_controller_core.sv =====
// top level of the snooping msi/mesi cache controller
// In the back end a request first reads the set's tag and state/lru rows from
// the set memories, then updates them and loads the result slots; a miss that
// evicts a modified line adds a second result (flush). A two-entry request
// queue in front keeps accepting, until it is full, while the back end works.
`default_nettype none
module snooping_coherent_cache_controller_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire scc_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output scc_pkg::out_t      out_data,
  input  wire logic          cfg_psel,
  input  wire logic          cfg_penable,
  input  wire logic          cfg_pwrite,
  input  wire logic [2:0]    cfg_paddr,
  input  wire logic [31:0]   cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  logic          mode_r;
  logic          q_valid, q_pop;
  scc_pkg::req_t q_data;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == scc_pkg::REG_MODE) ? {31'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && cfg_paddr[2] == scc_pkg::REG_MODE) begin
      mode_r <= cfg_pwdata[0];
    end
  end

  scc_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
  );

  scc_back u_back (
    .clk(clk), .rst_n(rst_n), .mode(mode_r),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );
endmodule
`default_nettype wire
